// File: design/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

  localparam int unsigned Steps = 17;
  localparam int unsigned VecW = 36;
  localparam int unsigned AngW = 20;
  localparam int unsigned SqW = 57;
  localparam int unsigned RootW = 57;
  localparam int unsigned SqSteps = 29;

  localparam logic signed [AngW-1:0] PiQ16 = 20'sd205887;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } cord_t;

  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [VecW-1:0] s;
    logic                   lock;
    logic                   neg;
  } pside_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int unsigned i);
    logic signed [AngW-1:0] t;
    t = '0;
    unique case (i)
      0: t = 20'sd51472;
      1: t = 20'sd30386;
      2: t = 20'sd16055;
      3: t = 20'sd8150;
      4: t = 20'sd4091;
      5: t = 20'sd2047;
      6: t = 20'sd1024;
      7: t = 20'sd512;
      8: t = 20'sd256;
      9: t = 20'sd128;
      10: t = 20'sd64;
      11: t = 20'sd32;
      12: t = 20'sd16;
      13: t = 20'sd8;
      14: t = 20'sd4;
      15: t = 20'sd2;
      16: t = 20'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: design/quaternion_to_euler_angles.sv
// Converts one Q2.14 quaternion (w, x, y, z) per transfer into Z-Y-X Euler angles in
// Q3.13 radians plus a gimbal-lock flag. A new quaternion can be taken every cycle
// while the output is not stalled; each result passes through the product registers, 29 cells of
// the square-root chain feeding the pitch cosine, the pre-rotation register,
// 17 cordic cells and 1 output register. Backpressure stalls the whole chain.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // q_w, q_x, q_y, q_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
  output logic             out_tuser   // gimbal_lock
);

  localparam int unsigned Lat = 2 + q2e_pkg::SqSteps + 1 + q2e_pkg::Steps;

  logic en;
  logic [Lat-1:0] vld_r;
  logic out_v_r;

  assign en = !out_v_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
      out_v_r <= vld_r[Lat-1];
    end
  end
  assign out_tvalid = out_v_r;

  // products
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= qw * qx; yz_r <= qy * qz; xx_r <= qx * qx;
      yy_r <= qy * qy; wz_r <= qw * qz; xy_r <= qx * qy;
      zz_r <= qz * qz; wy_r <= qw * qy; zx_r <= qz * qx;
    end
  end

  localparam logic signed [q2e_pkg::VecW-1:0] One = q2e_pkg::VecW'(64'sd1 << 28);
  logic signed [q2e_pkg::VecW-1:0] ry_r, rx_r, yy2_r, yx_r, s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ry_r <= 36'(2 * (36'(wx_r) + 36'(yz_r)));
      rx_r <= One - 36'(2 * (36'(xx_r) + 36'(yy_r)));
      yy2_r <= 36'(2 * (36'(wz_r) + 36'(xy_r)));
      yx_r <= One - 36'(2 * (36'(yy_r) + 36'(zz_r)));
      s_r <= 36'(2 * (36'(wy_r) - 36'(zx_r)));
    end
  end

  // |s| < 2^28 for square-root path; s*s needs a 56-bit product split in two
  logic [27:0] sabs;
  logic lock0, neg0;
  assign lock0 = (s_r >= One) || (s_r <= -One);
  assign neg0 = s_r[q2e_pkg::VecW-1];
  assign sabs = neg0 ? 28'(-s_r) : 28'(s_r);

  logic [27:0] sa;
  assign sa = lock0 ? 28'd0 : sabs;
  logic [13:0] sh, sl;
  assign sh = sa[27:14];
  assign sl = sa[13:0];
  logic [27:0] phh, phl, pll;
  assign phh = sh * sh;
  assign phl = sh * sl;
  assign pll = sl * sl;
  logic [55:0] sq;
  assign sq = {phh, 28'd0} + 56'({phl, 15'd0}) + 56'(pll);

  q2e_pkg::sqrt_t sq_in;
  assign sq_in.rem = (q2e_pkg::SqW'(1) << 56) - q2e_pkg::SqW'(sq);
  assign sq_in.root = '0;

  // side chains carry the roll/yaw vectors and pitch sine through the sqrt delay
  localparam int unsigned SD = q2e_pkg::SqSteps;
  q2e_pkg::sqrt_t sq_c [SD+1];
  logic signed [q2e_pkg::VecW-1:0] rxd_r [SD], ryd_r [SD], yxd_r [SD], yyd_r [SD];
  q2e_pkg::pside_t ps_r [SD];
  assign sq_c[0] = sq_in;

  for (genvar g = 0; g < SD; g++) begin : g_sq
    q2e_sqrt_cell u_cell (
      .clk(clk), .en(en), .d_in(sq_c[g]),
      .step(5'(SD - 1 - g)), .d_out_r(sq_c[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        if (g == 0) begin
          rxd_r[g] <= rx_r; ryd_r[g] <= ry_r; yxd_r[g] <= yx_r; yyd_r[g] <= yy2_r;
          ps_r[g] <= '{s: s_r, lock: lock0, neg: neg0};
        end else begin
          rxd_r[g] <= rxd_r[g-1]; ryd_r[g] <= ryd_r[g-1];
          yxd_r[g] <= yxd_r[g-1]; yyd_r[g] <= yyd_r[g-1];
          ps_r[g] <= ps_r[g-1];
        end
      end
    end
  end

  function automatic q2e_pkg::cord_t pre(input logic signed [q2e_pkg::VecW-1:0] y,
                                         input logic signed [q2e_pkg::VecW-1:0] x);
    q2e_pkg::cord_t c;
    c.zero = (x == 0) && (y == 0);
    c.x = x; c.y = y; c.z = '0;
    if (x < 0) begin
      c.z = (y >= 0) ? q2e_pkg::PiQ16 : -q2e_pkg::PiQ16;
      c.x = -x; c.y = -y;
    end
    return c;
  endfunction

  q2e_pkg::cord_t cr [q2e_pkg::Steps+1], cyw [q2e_pkg::Steps+1], cp [q2e_pkg::Steps+1];
  logic [q2e_pkg::Steps:0] lk_r, ng_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= pre(ryd_r[SD-1], rxd_r[SD-1]);
      cyw[0] <= pre(yyd_r[SD-1], yxd_r[SD-1]);
      cp[0] <= pre(ps_r[SD-1].s,
                   q2e_pkg::VecW'({1'b0, sq_c[SD].root}));
      lk_r <= {lk_r[q2e_pkg::Steps-1:0], ps_r[SD-1].lock};
      ng_r <= {ng_r[q2e_pkg::Steps-1:0], ps_r[SD-1].neg};
    end
  end

  for (genvar g = 0; g < q2e_pkg::Steps; g++) begin : g_cd
    q2e_cordic_cell u_r (.clk(clk), .en(en), .d_in(cr[g]), .step(5'(g)),
                         .d_out_r(cr[g+1]));
    q2e_cordic_cell u_y (.clk(clk), .en(en), .d_in(cyw[g]), .step(5'(g)),
                         .d_out_r(cyw[g+1]));
    q2e_cordic_cell u_p (.clk(clk), .en(en), .d_in(cp[g]), .step(5'(g)),
                         .d_out_r(cp[g+1]));
  end

  function automatic logic signed [15:0] fin(input q2e_pkg::cord_t c,
                                             input logic signed [15:0] lim);
    logic signed [q2e_pkg::AngW-1:0] a;
    a = (c.z + 20'sd4) >>> 3;
    if (c.zero) return '0;
    if (a > q2e_pkg::AngW'(lim)) return lim;
    if (a < -q2e_pkg::AngW'(lim)) return -lim;
    return 16'(a);
  endfunction

  logic signed [15:0] roll_r, yaw_r, pitch_r;
  logic lock_r;
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r <= fin(cr[q2e_pkg::Steps], q2e_pkg::PiQ13);
      yaw_r <= fin(cyw[q2e_pkg::Steps], q2e_pkg::PiQ13);
      lock_r <= lk_r[q2e_pkg::Steps];
      if (lk_r[q2e_pkg::Steps]) begin
        pitch_r <= ng_r[q2e_pkg::Steps] ? -q2e_pkg::HalfPiQ13 : q2e_pkg::HalfPiQ13;
      end else begin
        pitch_r <= fin(cp[q2e_pkg::Steps], q2e_pkg::HalfPiQ13);
      end
    end
  end

  assign out_tdata = {1'b0, yaw_r, pitch_r[14:0], roll_r};
  assign out_tuser = lock_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");
  a_lock_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (pitch_r == q2e_pkg::HalfPiQ13 ||
                                 pitch_r == -q2e_pkg::HalfPiQ13))
    else $error("lock without saturated pitch");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (roll_r <= q2e_pkg::PiQ13 && roll_r >= -q2e_pkg::PiQ13))
    else $error("roll out of range");
`endif

endmodule
`default_nettype wire

// File: design/q2e_cordic_cell.sv
`default_nettype none
module q2e_cordic_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire q2e_pkg::cord_t d_in,
  input  wire logic [4:0]     step,
  output q2e_pkg::cord_t      d_out_r
);

  q2e_pkg::cord_t d_nxt;

  always_comb begin
    d_nxt = d_in;
    if (d_in.y >= 0) begin
      d_nxt.x = d_in.x + (d_in.y >>> step);
      d_nxt.y = d_in.y - (d_in.x >>> step);
      d_nxt.z = d_in.z + q2e_pkg::atan_tab(32'(step));
    end else begin
      d_nxt.x = d_in.x - (d_in.y >>> step);
      d_nxt.y = d_in.y + (d_in.x >>> step);
      d_nxt.z = d_in.z - q2e_pkg::atan_tab(32'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/q2e_sqrt_cell.sv
`default_nettype none
module q2e_sqrt_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire q2e_pkg::sqrt_t d_in,
  input  wire logic [4:0]     step,
  output q2e_pkg::sqrt_t      d_out_r
);

  // one result bit per cell, msb first
  q2e_pkg::sqrt_t d_nxt;
  logic [q2e_pkg::SqW-1:0] trial;
  logic [q2e_pkg::SqW-1:0] bitv;

  always_comb begin
    bitv = q2e_pkg::SqW'(1) << (6'(2) * 6'(step));
    trial = q2e_pkg::SqW'(d_in.root) + bitv;
    d_nxt = d_in;
    if (d_in.rem >= trial) begin
      d_nxt.rem = d_in.rem - trial;
      d_nxt.root = q2e_pkg::RootW'((q2e_pkg::SqW'(d_in.root) >> 1) + bitv);
    end else begin
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire
